// ----- rtl/net_pkg.sv -----
// Shared constants, register codes and types for the nested encloser tokenizer.
package net_pkg;

    // Character and field widths.
    localparam int CHAR_BITS     = 8;
    localparam int FIELD_BITS    = 16;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    // Slots in the delimiter and encloser sets.
    localparam int DELIM_SLOTS = 8;
    localparam int PAIR_SLOTS  = 4;
    localparam int PAIR_WIDTH  = 2;
    localparam int PAIR_BYTES  = PAIR_SLOTS * PAIR_WIDTH;

    // Widths of the count registers.
    localparam int DCOUNT_BITS = 4;
    localparam int PCOUNT_BITS = 3;

    // The character that ends a string.
    localparam logic [CHAR_BITS-1:0] END_CHAR = 8'h00;

    // Parameter defaults for the top level.
    localparam int NEST_DEPTH_DEF = 16;
    localparam int POS_BITS_DEF   = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DELIM_CHARS = 2'd0,
        REG_DELIM_COUNT = 2'd1,
        REG_PAIR_CHARS  = 2'd2,
        REG_PAIR_COUNT  = 2'd3
    } cfg_reg_t;

    // What the classifier finds out about one character.
    typedef struct packed {
        logic                 is_end;
        logic                 open_hit;
        logic                 close_hit;
        logic                 delim_hit;
        logic [CHAR_BITS-1:0] closer;
    } net_class_t;

endpackage

// ----- rtl/nested_encloser_tokenizer.sv -----
// Top level of the nested encloser tokenizer: registers, closer stack and token counters.
//
// Usage: characters arrive one per transfer on the s_ channel (s_tdata, a zero byte ends the
// string). Each delimiter seen while no encloser pair is open, and each end marker, yields one
// token record on the m_ channel: start offset, length and index in m_tdata, m_tlast set for
// the token closed by the end marker, and m_tuser carrying the sticky nesting overflow flag.
// The delimiter and encloser sets are loaded through cfg_wr_en/cfg_index/cfg_wdata; the user
// must load them only while the block is idle, which the block itself does not enforce.
// A token record passes through the input register and then the result register before it
// is offered on the m_ channel.
// Throughput: one character per cycle unless the receiver stalls; the classifier compares, the
// closer stack (shift stack, top in a fixed register) and counters settle within that cycle.
// Reset clears the configuration, the stack level, the position and token counters and the
// overflow flag; the stack contents themselves are not cleared.
// When the receiver stalls, the pending record is held; one more character is taken into the
// input register, and s_tready then falls until the record has been transferred.
module nested_encloser_tokenizer #(
    parameter int NEST_DEPTH = net_pkg::NEST_DEPTH_DEF,
    parameter int POS_BITS   = net_pkg::POS_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Character input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] ch
    // Token output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // [15:0] token_start,
                                                           // [31:16] token_length,
                                                           // [47:32] token_number
    output logic                                m_tlast,   // last_token
    output logic [0:0]                          m_tuser,   // [0] nest_overflow
    // Configuration writes.
    input  logic                                cfg_wr_en,
    input  logic [net_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [net_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    localparam int LVL_BITS = $clog2(NEST_DEPTH + 1);
    localparam int FB       = net_pkg::FIELD_BITS;

    // Configuration registers.
    logic [net_pkg::CFG_DATA_BITS-1:0] delim_chars_reg;
    logic [net_pkg::DCOUNT_BITS-1:0]   delim_count_reg;
    logic [net_pkg::CFG_DATA_BITS-1:0] pair_chars_reg;
    logic [net_pkg::PCOUNT_BITS-1:0]   pair_count_reg;

    // Input stage.
    logic                         in_valid_reg;
    logic [net_pkg::CHAR_BITS-1:0] ch_reg;

    // Tokenizer state.
    logic [net_pkg::CHAR_BITS-1:0] stack_reg [NEST_DEPTH];
    logic [LVL_BITS-1:0]           level_reg, level_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [POS_BITS-1:0]           start_reg, start_next;
    logic [FB-1:0]                 tok_reg, tok_next;
    logic                          ovf_reg, ovf_next;

    // Result stage.
    logic          out_valid_reg;
    logic [FB-1:0] out_start_reg, out_len_reg, out_num_reg;
    logic          out_last_reg, out_ovf_reg;

    net_pkg::net_class_t cls;
    logic                proc_fire;
    logic                full, top_match, push, pop, delim_emit, emit, ovf_now;
    logic [POS_BITS-1:0] len;
    logic [31:0]         start_wide, len_wide;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_chars_reg <= '0;
            delim_count_reg <= '0;
            pair_chars_reg  <= '0;
            pair_count_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                net_pkg::REG_DELIM_CHARS: delim_chars_reg <= cfg_wdata;
                net_pkg::REG_DELIM_COUNT:
                    delim_count_reg <= cfg_wdata[net_pkg::DCOUNT_BITS-1:0];
                net_pkg::REG_PAIR_CHARS:  pair_chars_reg <= cfg_wdata;
                net_pkg::REG_PAIR_COUNT:
                    pair_count_reg <= cfg_wdata[net_pkg::PCOUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The held character moves on whenever the result register can take its outcome.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    net_classify u_classify (
        .ch              (ch_reg),
        .delimiter_chars (delim_chars_reg),
        .delimiter_count (delim_count_reg),
        .pair_chars      (pair_chars_reg),
        .pair_count      (pair_count_reg),
        .cls             (cls)
    );

    // Stack action and next state for the held character.
    assign full      = (level_reg == LVL_BITS'(NEST_DEPTH));
    assign top_match = (level_reg != '0) && (stack_reg[0] == ch_reg);
    assign push      = cls.open_hit && !full;
    assign pop       = cls.close_hit && top_match;
    assign ovf_now   = ovf_reg | (cls.open_hit & full);
    assign len       = pos_reg - start_reg;

    always_comb begin
        if (cls.is_end) begin
            level_next = '0;
        end else if (push) begin
            level_next = level_reg + LVL_BITS'(1);
        end else if (pop) begin
            level_next = level_reg - LVL_BITS'(1);
        end else begin
            level_next = level_reg;
        end
    end

    assign delim_emit = cls.delim_hit && (level_next == '0);
    assign emit       = cls.is_end || delim_emit;
    assign ovf_next   = cls.is_end ? 1'b0 : ovf_now;
    assign pos_next   = cls.is_end ? '0 : pos_reg + POS_BITS'(1);
    assign start_next = cls.is_end ? '0 : (delim_emit ? pos_reg + POS_BITS'(1) : start_reg);
    assign tok_next   = cls.is_end ? '0 : (delim_emit ? tok_reg + FB'(1) : tok_reg);

    // Counters and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            tok_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (proc_fire) begin
            level_reg <= level_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            tok_reg   <= tok_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Closer stack as a shift stack: the top always sits in entry zero.
    always_ff @(posedge aclk) begin
        if (proc_fire && push) begin
            stack_reg[0] <= cls.closer;
            for (int i = 1; i < NEST_DEPTH; i++) begin
                stack_reg[i] <= stack_reg[i-1];
            end
        end else if (proc_fire && pop) begin
            for (int i = 0; i < NEST_DEPTH - 1; i++) begin
                stack_reg[i] <= stack_reg[i+1];
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= emit;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign start_wide = 32'(start_reg);
    assign len_wide   = 32'(len);

    always_ff @(posedge aclk) begin
        if (proc_fire && emit) begin
            out_start_reg <= start_wide[FB-1:0];
            out_len_reg   <= len_wide[FB-1:0];
            out_num_reg   <= tok_reg;
            out_last_reg  <= cls.is_end;
            out_ovf_reg   <= cls.is_end ? ovf_reg : ovf_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_num_reg, out_len_reg, out_start_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

    // The stack level never goes past the depth of the stack.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_BITS'(NEST_DEPTH))
        else $error("stack level beyond stack depth");

    // An end marker leaves the block ready for a fresh string.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && cls.is_end |=> level_reg == '0 && pos_reg == '0 && tok_reg == '0
            && !ovf_reg)
        else $error("state not cleared after end of string");

    // Every token that is found is offered on the output.
    a_emit_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && emit |=> m_tvalid)
        else $error("token record lost");

    // The overflow flag only rises on an opener that meets a full stack.
    a_ovf_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(proc_fire && cls.open_hit && full))
        else $error("overflow flag set without a dropped opener");

endmodule

// ----- rtl/net_classify.sv -----
// Character classifier: compares one character against the delimiter and encloser sets.
module net_classify (
    input  logic [net_pkg::CHAR_BITS-1:0]     ch,
    input  logic [net_pkg::CFG_DATA_BITS-1:0] delimiter_chars,
    input  logic [net_pkg::DCOUNT_BITS-1:0]   delimiter_count,
    input  logic [net_pkg::CFG_DATA_BITS-1:0] pair_chars,
    input  logic [net_pkg::PCOUNT_BITS-1:0]   pair_count,
    output net_pkg::net_class_t               cls
);

    logic [net_pkg::DCOUNT_BITS-1:0] delims_eff;
    logic [net_pkg::PCOUNT_BITS-1:0] pairs_eff;
    logic                            is_end;
    logic                            delim_hit;

    // Counts above the number of slots count as all slots.
    assign delims_eff = (delimiter_count > net_pkg::DCOUNT_BITS'(net_pkg::DELIM_SLOTS)) ?
                        net_pkg::DCOUNT_BITS'(net_pkg::DELIM_SLOTS) : delimiter_count;
    assign pairs_eff  = (pair_count > net_pkg::PCOUNT_BITS'(net_pkg::PAIR_SLOTS)) ?
                        net_pkg::PCOUNT_BITS'(net_pkg::PAIR_SLOTS) : pair_count;
    assign is_end     = (ch == net_pkg::END_CHAR);

    // The lowest matching encloser byte decides; the end marker never matches.
    always_comb begin
        logic found;
        found         = 1'b0;
        cls.is_end    = is_end;
        cls.open_hit  = 1'b0;
        cls.close_hit = 1'b0;
        cls.delim_hit = delim_hit;
        cls.closer    = '0;
        for (int k = 0; k < net_pkg::PAIR_BYTES; k++) begin
            if (!found && !is_end && (net_pkg::PCOUNT_BITS'(k / net_pkg::PAIR_WIDTH) < pairs_eff)
                    && (pair_chars[8*k +: 8] == ch)) begin
                found = 1'b1;
                if ((k % net_pkg::PAIR_WIDTH) == 0) begin
                    cls.open_hit = 1'b1;
                    cls.closer   = pair_chars[8*(k | 1) +: 8];
                end else begin
                    cls.close_hit = 1'b1;
                end
            end
        end
    end

    // Delimiter match against the valid slots.
    always_comb begin
        delim_hit = 1'b0;
        for (int k = 0; k < net_pkg::DELIM_SLOTS; k++) begin
            if (!is_end && (net_pkg::DCOUNT_BITS'(k) < delims_eff)
                    && (delimiter_chars[8*k +: 8] == ch)) begin
                delim_hit = 1'b1;
            end
        end
    end

endmodule

// ----- tb/sv/token_check_pkg.sv -----
// Token record type and the scoreboard that predicts and checks the tokenizer's records.
package token_check_pkg;
    import net_pkg::*;

    // One token record as it leaves the block.
    typedef struct packed {
        logic [15:0] tok_start;
        logic [15:0] tok_len;
        logic [15:0] tok_index;
        logic        at_end;
        logic        overflow;
    } token_t;

    class token_scoreboard;
        // Configuration as last written.
        logic [63:0] delim_set;
        logic [3:0]  delim_num;
        logic [63:0] pair_set;
        logic [2:0]  pair_num;

        // Tokenizer state.
        logic [7:0]  closers [NEST_DEPTH_DEF];
        int unsigned depth;
        logic [15:0] pos;
        logic [15:0] tok_begin;
        logic [15:0] tok_count;
        logic        dropped;

        token_t      expected_tokens [$];
        int unsigned mismatches;

        function new();
            delim_set  = '0;
            delim_num  = '0;
            pair_set   = '0;
            pair_num   = '0;
            depth      = 0;
            pos        = '0;
            tok_begin  = '0;
            tok_count  = '0;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] value);
            case (idx)
                REG_DELIM_CHARS: delim_set = value;
                REG_DELIM_COUNT: delim_num = value[DCOUNT_BITS-1:0];
                REG_PAIR_CHARS:  pair_set  = value;
                REG_PAIR_COUNT:  pair_num  = value[PCOUNT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_tokens.size();
        endfunction

        // Counts above the number of slots behave as the full set.
        function bit is_delim(logic [7:0] c);
            int unsigned n;
            n = (delim_num > DELIM_SLOTS) ? DELIM_SLOTS : delim_num;
            for (int k = 0; k < n; k++) begin
                if (delim_set[k*8 +: 8] == c) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function token_t make_token(logic last);
            token_t t;
            t.tok_start = tok_begin;
            t.tok_len   = pos - tok_begin;
            t.tok_index = tok_count;
            t.at_end    = last;
            t.overflow  = dropped;
            return t;
        endfunction

        // Predict the effect of one accepted character.
        function void note_char(logic [7:0] c);
            int unsigned n;
            bit          hit;
            if (c == END_CHAR) begin
                expected_tokens.push_back(make_token(1'b1));
                depth     = 0;
                pos       = '0;
                tok_begin = '0;
                tok_count = '0;
                dropped   = 1'b0;
                return;
            end

            // The lowest matching encloser byte decides; an even byte is an opener.
            n   = ((pair_num > PAIR_SLOTS) ? PAIR_SLOTS : pair_num) * PAIR_WIDTH;
            hit = 1'b0;
            for (int k = 0; k < n && !hit; k++) begin
                if (pair_set[k*8 +: 8] == c) begin
                    hit = 1'b1;
                    if (k % PAIR_WIDTH == 0) begin
                        if (depth < NEST_DEPTH_DEF) begin
                            closers[depth] = pair_set[(k+1)*8 +: 8];
                            depth++;
                        end else begin
                            dropped = 1'b1;
                        end
                    end else if (depth > 0 && closers[depth-1] == c) begin
                        depth--;
                    end
                end
            end

            // A delimiter only splits at the outermost level.
            if (depth == 0 && is_delim(c)) begin
                expected_tokens.push_back(make_token(1'b0));
                tok_begin = pos + 16'd1;
                tok_count = tok_count + 16'd1;
            end
            pos = pos + 16'd1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one transferred record with the oldest prediction.
        function void check_token(logic [47:0] data, logic last, logic ovf);
            token_t want;
            if (expected_tokens.size() == 0) begin
                $error("token record with none predicted: start %0d, length %0d, index %0d",
                       data[15:0], data[31:16], data[47:32]);
                mismatches++;
                return;
            end
            want = expected_tokens.pop_front();
            compare_field("token_start", want.tok_start, data[15:0]);
            compare_field("token_length", want.tok_len, data[31:16]);
            compare_field("token_number", want.tok_index, data[47:32]);
            compare_field("last_token", 16'(want.at_end), 16'(last));
            compare_field("nest_overflow", 16'(want.overflow), 16'(ovf));
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench: drives strings and set-ups into the tokenizer and checks every token.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import net_pkg::*;
    import token_check_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 125;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_PATTERN} rx_mode_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    cfg_reg_t    cfg_index = REG_DELIM_CHARS;
    logic [63:0] cfg_wdata = '0;

    token_scoreboard tok_sb;

    // Stimulus state shared by the driving tasks.
    logic [63:0] cur_delims;
    logic [3:0]  cur_dnum;
    logic [63:0] cur_pairs;
    logic [2:0]  cur_pnum;
    logic [7:0]  char_pool [6];
    int          burst_left   = 0;
    bit          gaps_on      = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_done    = 1'b0;
    int          quiet_cycles = 0;

    nested_encloser_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Every transfer on either channel goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tok_sb.note_char(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                tok_sb.check_token(m_tdata, m_tlast, m_tuser[0]);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("[nested_encloser_tokenizer] ERROR");
            $finish;
        end
    end

    // Receiver: stretches of differing readiness, and one long hold-off on request.
    initial begin : receiver
        rx_mode_t mode;
        int       stretch;
        int       tick;
        tick = 0;
        forever begin
            if (hold_request && !hold_done) begin
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            mode    = rx_mode_t'($urandom_range(0, 3));
            stretch = $urandom_range(16, 160);
            repeat (stretch) begin
                // A pending hold-off starts at once, while the sender is still busy.
                if (hold_request && !hold_done) begin
                    break;
                end
                @(posedge aclk);
                tick++;
                case (mode)
                    RX_ALWAYS:  m_tready <= 1'b1;
                    RX_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
                    default:    m_tready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    function automatic logic [7:0] any_char();
        return 8'($urandom_range(1, 255));
    endfunction

    // A byte of a set; a zero byte would end the string, so something else goes instead.
    function automatic logic [7:0] set_char(logic [63:0] set, int unsigned k);
        logic [7:0] b;
        b = set[k*8 +: 8];
        return (b == END_CHAR) ? any_char() : b;
    endfunction

    // A set word drawn from a small pool so that the sets overlap, with some zero bytes.
    function automatic logic [63:0] pool_word();
        logic [63:0] w;
        for (int k = 0; k < 8; k++) begin
            w[k*8 +: 8] = ($urandom_range(0, 7) == 0) ? END_CHAR
                                                      : char_pool[$urandom_range(0, 5)];
        end
        return w;
    endfunction

    // One character transfer, with sender gaps between bursts.
    task automatic push_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap        = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait until every predicted token has arrived and the pipeline has drained.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tok_sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        tok_sb.set_reg(idx, value);
    endtask

    // Count registers get random upper bits, which the block must ignore.
    task automatic load_config(input logic [63:0] dchars, input logic [3:0] dnum,
                               input logic [63:0] pchars, input logic [2:0] pnum);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_DELIM_CHARS, dchars);
        write_reg(REG_DELIM_COUNT, {noise[63:4], dnum});
        write_reg(REG_PAIR_CHARS, pchars);
        write_reg(REG_PAIR_COUNT, {noise[63:3], pnum});
        cfg_wr_en  <= 1'b0;
        cur_delims = dchars;
        cur_dnum   = dnum;
        cur_pairs  = pchars;
        cur_pnum   = pnum;
    endtask

    // One string: mostly balanced nesting with random content, some stray closers and noise.
    task automatic send_random_string(output int unsigned sent);
        logic [7:0]  open_closers [$];
        logic [7:0]  c;
        int unsigned eff_d;
        int unsigned eff_p;
        int unsigned len;
        int unsigned pick;
        int unsigned k;
        eff_d = (cur_dnum > DELIM_SLOTS) ? DELIM_SLOTS : cur_dnum;
        eff_p = (cur_pnum > PAIR_SLOTS) ? PAIR_SLOTS : cur_pnum;
        len   = $urandom_range(0, 30);
        sent  = 0;

        // Now and then run the closer stack past full.
        if (eff_p != 0 && $urandom_range(0, 9) == 0) begin
            repeat (NEST_DEPTH_DEF + $urandom_range(1, 4)) begin
                push_char(set_char(cur_pairs, $urandom_range(0, eff_p - 1) * PAIR_WIDTH));
                sent++;
            end
        end

        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && eff_p != 0) begin
                k = $urandom_range(0, eff_p - 1) * PAIR_WIDTH;
                c = set_char(cur_pairs, k);
                open_closers.push_back(set_char(cur_pairs, k + 1));
            end else if (pick < 45 && open_closers.size() != 0) begin
                c = open_closers.pop_back();
            end else if (pick < 70 && eff_d != 0) begin
                c = set_char(cur_delims, $urandom_range(0, eff_d - 1));
            end else if (pick < 75 && eff_p != 0) begin
                c = set_char(cur_pairs, $urandom_range(0, eff_p - 1) * PAIR_WIDTH + 1);
            end else begin
                c = any_char();
            end
            push_char(c);
            sent++;
        end
        push_char(END_CHAR);
        sent++;
    endtask

    initial begin : stimulus
        logic [7:0]  directed_chars [21];
        logic [63:0] dchars;
        logic [63:0] pchars;
        logic [3:0]  dnum;
        logic [2:0]  pnum;
        int unsigned phase_items;
        int unsigned sent;

        tok_sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed set-up: ',' and ';' split; (), [], "" (opener equals closer) and {} nest.
        load_config(64'h3B2C, 4'd2, 64'h7D7B_2222_5D5B_2928, 3'd4);
        directed_chars = '{")", 8'hFF, "a", ",", "(", "b", ",", "]", ")", ";", "[",
                           "{", "}", "]", 8'h01, "\"", ",", "\"", ",", END_CHAR, END_CHAR};
        foreach (directed_chars[i]) begin
            push_char(directed_chars[i]);
        end

        // Random phases, each with its own set-up, the extremes among them.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            foreach (char_pool[i]) begin
                char_pool[i] = any_char();
            end
            case (ph)
                0: begin
                    dchars = pool_word();
                    dnum   = 4'd0;
                    pchars = pool_word();
                    pnum   = 3'd4;
                end
                1: begin
                    dchars = {$urandom, $urandom};
                    dnum   = 4'd8;
                    pchars = {$urandom, $urandom};
                    pnum   = 3'd0;
                end
                2: begin
                    dchars = {$urandom, $urandom};
                    dnum   = 4'd15;
                    pchars = {$urandom, $urandom};
                    pnum   = 3'd7;
                end
                3: begin
                    // Delimiters that are also an opener and a closer.
                    dchars = 64'h3C3E;
                    dnum   = 4'd2;
                    pchars = pool_word();
                    pchars[31:0] = 32'h2727_3E3C;
                    pnum   = 3'd4;
                end
                default: begin
                    dchars = pool_word();
                    dnum   = 4'($urandom_range(0, 15));
                    pchars = pool_word();
                    pnum   = 3'($urandom_range(0, 7));
                end
            endcase
            settle();
            load_config(dchars, dnum, pchars, pnum);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                send_random_string(sent);
                phase_items += sent;
                // Partway into the first phase the receiver holds off for a long stretch.
                if (ph == 0 && phase_items >= 40) begin
                    hold_request = 1'b1;
                end
            end
        end

        settle();
        if (tok_sb.mismatches == 0 && tok_sb.pending() == 0) begin
            $display("[nested_encloser_tokenizer] OK");
        end else begin
            $display("[nested_encloser_tokenizer] ERROR");
        end
        $finish;
    end

endmodule
